FILE: hw/rtl/mcualu_pkg.sv
// Shared types and constants for the midrange MCU ALU execute core.
package mcualu_pkg;

   localparam int unsigned ADDR_WIDTH_DEFAULT = 7;
   localparam int unsigned FILE_ADDR_BITS     = 7;

   typedef enum logic [4:0] {
      KIND_ADD    = 5'd0,
      KIND_AND    = 5'd1,
      KIND_CLRF   = 5'd2,
      KIND_CLRW   = 5'd3,
      KIND_COM    = 5'd4,
      KIND_DEC    = 5'd5,
      KIND_DECSZ  = 5'd6,
      KIND_INC    = 5'd7,
      KIND_INCSZ  = 5'd8,
      KIND_OR     = 5'd9,
      KIND_MOVF   = 5'd10,
      KIND_MOVWF  = 5'd11,
      KIND_RLF    = 5'd12,
      KIND_RRF    = 5'd13,
      KIND_SUB    = 5'd14,
      KIND_SWAP   = 5'd15,
      KIND_XOR    = 5'd16,
      KIND_BCF    = 5'd17,
      KIND_BSF    = 5'd18,
      KIND_BTFSC  = 5'd19,
      KIND_BTFSS  = 5'd20,
      KIND_ANDLW  = 5'd21,
      KIND_IORLW  = 5'd22,
      KIND_MOVLW  = 5'd23,
      KIND_XORLW  = 5'd24,
      KIND_NOP    = 5'd25
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [7:0]                file_value;
      logic [FILE_ADDR_BITS-1:0] file_address;
      logic [7:0]                literal;
      logic [2:0]                bit_index;
      logic                      to_file;
   } req_type;

   // architectural state: W and status bits
   typedef struct packed {
      logic [7:0] w;
      logic       zero;
      logic       carry;
      logic       digit_carry;
   } status_type;

   typedef struct packed {
      logic [7:0]                write_value;
      logic                      write_enable;
      logic [FILE_ADDR_BITS-1:0] write_address;
      logic [7:0]                w_value;
      logic                      zero_flag;
      logic                      carry_flag;
      logic                      digit_carry_flag;
      logic                      skip_next;
   } rsp_type;

endpackage

FILE: hw/rtl/mcualu_alu.sv
// Combinational ALU: one decoded instruction against the current W and flags.
module mcualu_alu #(
   parameter int unsigned ADDR_WIDTH = mcualu_pkg::ADDR_WIDTH_DEFAULT
) (
   input  mcualu_pkg::req_type    req,
   input  mcualu_pkg::status_type status,
   output mcualu_pkg::status_type status_next,
   output mcualu_pkg::rsp_type    rsp
);

   localparam int unsigned AddrBits = mcualu_pkg::FILE_ADDR_BITS;
   localparam int unsigned MaskBits = (ADDR_WIDTH < AddrBits) ? ADDR_WIDTH : AddrBits;
   localparam logic [AddrBits-1:0] AddrMask = AddrBits'((1 << MaskBits) - 1);

   logic [7:0] f;
   logic [7:0] w;
   logic [7:0] bit_mask;
   logic [8:0] add_sum;
   logic [4:0] add_nib;
   logic [8:0] sub_diff;
   logic [4:0] sub_nib;
   logic [7:0] res;
   logic       byte_op;
   logic       set_z;
   logic       wr;
   logic [7:0] wval;
   logic       skip;
   mcualu_pkg::status_type st;

   assign f        = req.file_value;
   assign w        = status.w;
   assign bit_mask = 8'h01 << req.bit_index;
   assign add_sum  = {1'b0, f} + {1'b0, w};
   assign add_nib  = {1'b0, f[3:0]} + {1'b0, w[3:0]};
   // borrow shows up in the top bit; carry flags are not-borrow
   assign sub_diff = {1'b0, f} - {1'b0, w};
   assign sub_nib  = {1'b0, f[3:0]} - {1'b0, w[3:0]};

   always_comb begin
      st      = status;
      res     = 8'h00;
      byte_op = 1'b0;
      set_z   = 1'b0;
      wr      = 1'b0;
      wval    = 8'h00;
      skip    = 1'b0;
      case (req.kind)
         mcualu_pkg::KIND_ADD: begin
            res            = add_sum[7:0];
            st.carry       = add_sum[8];
            st.digit_carry = add_nib[4];
            byte_op        = 1'b1;
            set_z          = 1'b1;
         end
         mcualu_pkg::KIND_AND: begin
            res = f & w; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_CLRF: begin
            wr = 1'b1; st.zero = 1'b1;
         end
         mcualu_pkg::KIND_CLRW: begin
            st.w = 8'h00; st.zero = 1'b1;
         end
         mcualu_pkg::KIND_COM: begin
            res = f ^ 8'hff; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_DEC: begin
            res = f - 8'h01; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_DECSZ: begin
            res = f - 8'h01; byte_op = 1'b1; skip = (f == 8'h01);
         end
         mcualu_pkg::KIND_INC: begin
            res = f + 8'h01; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_INCSZ: begin
            res = f + 8'h01; byte_op = 1'b1; skip = (f == 8'hff);
         end
         mcualu_pkg::KIND_OR: begin
            res = f | w; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_MOVF: begin
            res = f; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_MOVWF: begin
            wr = 1'b1; wval = w;
         end
         mcualu_pkg::KIND_RLF: begin
            res      = {f[6:0], status.carry};
            st.carry = f[7];
            byte_op  = 1'b1;
         end
         mcualu_pkg::KIND_RRF: begin
            res      = {status.carry, f[7:1]};
            st.carry = f[0];
            byte_op  = 1'b1;
         end
         mcualu_pkg::KIND_SUB: begin
            res            = sub_diff[7:0];
            st.carry       = ~sub_diff[8];
            st.digit_carry = ~sub_nib[4];
            byte_op        = 1'b1;
            set_z          = 1'b1;
         end
         mcualu_pkg::KIND_SWAP: begin
            res = {f[3:0], f[7:4]}; byte_op = 1'b1;
         end
         mcualu_pkg::KIND_XOR: begin
            res = f ^ w; byte_op = 1'b1; set_z = 1'b1;
         end
         mcualu_pkg::KIND_BCF: begin
            wr = 1'b1; wval = f & ~bit_mask;
         end
         mcualu_pkg::KIND_BSF: begin
            wr = 1'b1; wval = f | bit_mask;
         end
         mcualu_pkg::KIND_BTFSC: skip = ((f & bit_mask) == 8'h00);
         mcualu_pkg::KIND_BTFSS: skip = ((f & bit_mask) != 8'h00);
         mcualu_pkg::KIND_ANDLW: begin
            st.w = w & req.literal; st.zero = ((w & req.literal) == 8'h00);
         end
         mcualu_pkg::KIND_IORLW: begin
            st.w = w | req.literal; st.zero = ((w | req.literal) == 8'h00);
         end
         mcualu_pkg::KIND_MOVLW: st.w = req.literal;
         mcualu_pkg::KIND_XORLW: begin
            st.w = w ^ req.literal; st.zero = ((w ^ req.literal) == 8'h00);
         end
         default: ;  // nop and unused codes
      endcase

      if (byte_op) begin
         if (req.to_file) begin
            wr   = 1'b1;
            wval = res;
         end else begin
            st.w = res;
         end
         if (set_z) begin
            st.zero = (res == 8'h00);
         end
      end
   end

   assign status_next = st;

   always_comb begin
      rsp                  = '0;
      rsp.write_value      = wr ? wval : 8'h00;
      rsp.write_enable     = wr;
      rsp.write_address    = req.file_address & AddrMask;
      rsp.w_value          = st.w;
      rsp.zero_flag        = st.zero;
      rsp.carry_flag       = st.carry;
      rsp.digit_carry_flag = st.digit_carry;
      rsp.skip_next        = skip;
   end

endmodule

FILE: hw/rtl/midrange_mcu_alu_execute_core.sv
// Top level of the midrange MCU ALU execute core: request register, ALU, result register.
//
// Takes one request per cycle while req_stall is low and returns one result per request.
// A request accepted into the request register is executed there by the ALU and moves
// into the result register when that slot is empty or draining, where its result is
// presented until taken. W and the Z/C/DC bits are updated in the same cycle a request
// moves from the request register into the result register, so the following request
// always sees them. A stalled result holds the pipe: req_stall rises once the request
// register is full and the result register cannot drain. write_address is file_address
// masked to ADDR_WIDTH bits, capped at FILE_ADDR_BITS.
module midrange_mcu_alu_execute_core #(
   parameter int unsigned ADDR_WIDTH = mcualu_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [4:0] req_kind,
   input  logic [7:0] req_file_value,
   input  logic [6:0] req_file_address,
   input  logic [7:0] req_literal,
   input  logic [2:0] req_bit_index,
   input  logic       req_to_file,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_write_value,
   output logic       rsp_write_enable,
   output logic [6:0] rsp_write_address,
   output logic [7:0] rsp_w_value,
   output logic       rsp_zero_flag,
   output logic       rsp_carry_flag,
   output logic       rsp_digit_carry_flag,
   output logic       rsp_skip_next
);

   logic                   req_valid_ff;
   logic                   req_valid_in;
   mcualu_pkg::req_type    req_ff;
   mcualu_pkg::req_type    req_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mcualu_pkg::rsp_type    rsp_ff;
   mcualu_pkg::rsp_type    alu_rsp;
   mcualu_pkg::status_type status_ff;
   mcualu_pkg::status_type status_in;
   mcualu_pkg::status_type alu_status;
   logic                   advance;
   logic                   req_take;

   // request register moves on when the result slot is empty or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_in              = req_ff;
      req_in.kind         = mcualu_pkg::kind_type'(req_kind);
      req_in.file_value   = req_file_value;
      req_in.file_address = req_file_address;
      req_in.literal      = req_literal;
      req_in.bit_index    = req_bit_index;
      req_in.to_file      = req_to_file;
   end

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign status_in    = advance ? alu_status : status_ff;

   mcualu_alu #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_alu (
      .req         (req_ff),
      .status      (status_ff),
      .status_next (alu_status),
      .rsp         (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= alu_rsp;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_write_value      = rsp_ff.write_value;
   assign rsp_write_enable     = rsp_ff.write_enable;
   assign rsp_write_address    = rsp_ff.write_address;
   assign rsp_w_value          = rsp_ff.w_value;
   assign rsp_zero_flag        = rsp_ff.zero_flag;
   assign rsp_carry_flag       = rsp_ff.carry_flag;
   assign rsp_digit_carry_flag = rsp_ff.digit_carry_flag;
   assign rsp_skip_next        = rsp_ff.skip_next;

   // a held result must match the live architectural state
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.w_value == status_ff.w && rsp_ff.zero_flag == status_ff.zero
                        && rsp_ff.carry_flag == status_ff.carry
                        && rsp_ff.digit_carry_flag == status_ff.digit_carry))
      else $error("result W/flags differ from state");

   a_state_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(status_ff))
      else $error("state changed while result stalled");

   a_no_write_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.write_enable) |-> rsp_ff.write_value == 8'h00)
      else $error("write value nonzero without write enable");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in pipe");

endmodule
